/* src/kpi_pkg.sv */
// shared constants, request codes and divider interface types for the keyframe interpolator
`timescale 1ns / 1ps

package kpi_pkg;

   // table geometry
   localparam int MaxKeys    = 16;
   localparam int KeyW       = $clog2(MaxKeys);
   localparam int CountW     = $clog2(MaxKeys + 1);
   localparam int JointCount = 19;
   localparam int JointW     = 5;
   localparam int AngDepth   = MaxKeys * (2 ** JointW);
   localparam int AngAddrW   = KeyW + JointW;

   // field widths
   localparam int TimeW      = 16;
   localparam int ValW       = 16;
   localparam int StepMargin = 3;

   // divider: 17 quotient bits per operation
   localparam int DivSteps   = 17;
   localparam int DivCntW    = $clog2(DivSteps);

   // request codes
   localparam logic [3:0] ReqAddKey    = 4'd0;
   localparam logic [3:0] ReqSetPose   = 4'd1;
   localparam logic [3:0] ReqTick      = 4'd2;
   localparam logic [3:0] ReqQueryPose = 4'd3;
   localparam logic [3:0] ReqQueryPos  = 4'd4;
   localparam logic [3:0] ReqRestart   = 4'd5;
   localparam logic [3:0] ReqPause     = 4'd6;
   localparam logic [3:0] ReqResume    = 4'd7;
   localparam logic [3:0] ReqToggle    = 4'd8;
   localparam logic [3:0] ReqNextKey   = 4'd9;
   localparam logic [3:0] ReqPrevKey   = 4'd10;

   // register indexes
   localparam logic CsrLoopLength = 1'b0;
   localparam logic CsrLoopEnable = 1'b1;

   // divider request and result
   typedef struct packed {
      logic                 start;
      logic [TimeW-1:0]     rem_init;
      logic [DivSteps-1:0]  dividend;
      logic [TimeW-1:0]     divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DivSteps-1:0]  quotient;
      logic [TimeW-1:0]     remainder;
   } div_rsp_type;

endpackage

/* src/keyframe_pose_interpolator.sv */
// keyframe table, play clock and linear pose interpolation sequencer
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  type, time, joint, x/y/z
//   rsp      out        rsp_valid/rsp_stall  x/y/z, play time, status
//   csr      in         csr_write_enable     index, 16-bit data
//
// one request at a time; req_stall is high from acceptance until the response is taken.
// add: key scan, then the shift state; tick: a single state, or a divider pass on a wrap.
// queries: bracket scan, the read states BR_DONE, RD_A, RD_B and RD_C, then for a blend
// a multiply and a serial divider pass for each of the three axes.
// every request ends with a status scan, then the output state.
// after reset a pass over all 512 angle memory words zeroes them with req_stall held high;
// a stalled response holds the block.
`timescale 1ns / 1ps

module keyframe_pose_interpolator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_type,
   input  logic [15:0]        req_time_value,
   input  logic [4:0]         req_joint_index,
   input  logic signed [15:0] req_val_x,
   input  logic signed [15:0] req_val_y,
   input  logic signed [15:0] req_val_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic [15:0]        rsp_play_time_now,
   output logic               rsp_is_paused,
   output logic [4:0]         rsp_key_count,
   output logic signed [4:0]  rsp_current_key,
   output logic               rsp_table_full_error,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data
);

   localparam int KW = kpi_pkg::KeyW;
   localparam int CW = kpi_pkg::CountW;
   localparam int TW = kpi_pkg::TimeW;
   localparam int VW = kpi_pkg::ValW;
   localparam int JW = kpi_pkg::JointW;
   localparam int NK = kpi_pkg::MaxKeys;
   localparam int NJ = kpi_pkg::JointCount;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_ADD_SCAN, ST_ADD_SHIFT, ST_TICK, ST_TICK_DIV, ST_BR_SCAN,
      ST_BR_DONE, ST_RD_A, ST_RD_B, ST_RD_C, ST_MUL, ST_DIV_GO, ST_DIV_WAIT, ST_NEXT,
      ST_PREV, ST_CUR, ST_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [TW-1:0] len_ff;
   logic          loop_en_ff;

   // key table: times and slot map in sorted order
   logic [TW-1:0] times_ff   [NK];
   logic [KW-1:0] ord_ff     [NK];
   logic [CW-1:0] count_ff;
   logic [KW-1:0] last_ff;

   // play state
   logic [TW-1:0] pt_ff;
   logic          paused_ff;

   // latched request
   logic [3:0]           cmd_type_ff;
   logic [TW-1:0]        cmd_time_ff;
   logic [JW-1:0]        cmd_joint_ff;
   logic signed [VW-1:0] cmd_val_ff [3];

   // sequencer working registers
   logic [CW-1:0]        idx_ff;
   logic [CW-1:0]        cidx_ff;
   logic [KW-1:0]        p_ff;
   logic [KW-1:0]        n_ff;
   logic                 found_ff;
   logic                 mix_ff;
   logic [TW-1:0]        tp_ff;
   logic [TW-1:0]        tn_ff;
   logic [TW-1:0]        tlast_ff;
   logic [KW-1:0]        op_ff;
   logic [KW-1:0]        on_ff;
   logic signed [VW-1:0] a_ff [3];
   logic signed [VW-1:0] b_ff [3];
   logic signed [VW-1:0] r_ff [3];
   logic [1:0]           k_ff;
   logic [2*TW-1:0]      prod_ff;
   logic                 neg_ff;
   logic                 err_ff;
   logic [kpi_pkg::AngAddrW-1:0] clr_ff;

   // memories
   logic [3*VW-1:0] pos_mem [NK];
   logic [3*VW-1:0] ang_mem [kpi_pkg::AngDepth];
   logic [3*VW-1:0] pos_q_ff;
   logic [3*VW-1:0] ang_q_ff;

   logic [KW-1:0]       rd_slot;
   logic [KW-1:0]       scan_addr;
   logic [TW-1:0]       scan_t;
   logic [TW:0]         tick_sum;
   logic                tick_wrap;
   logic                req_fire;
   logic                set_pose_ok;
   logic signed [VW:0]  diff;
   logic [VW:0]         diff_mag;
   logic [TW-1:0]       qmag;
   logic [TW-1:0]       qsigned;
   logic [TW:0]         pt_plus;

   kpi_pkg::div_req_type div_req;
   kpi_pkg::div_rsp_type div_rsp;

   kpi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign set_pose_ok = (count_ff != '0) && (req_joint_index < JW'(NJ));

   // scan read port over the sorted times, shared by the status scan and the other scans
   assign scan_addr = (state_ff == ST_CUR) ? cidx_ff[KW-1:0] : idx_ff[KW-1:0];
   assign scan_t    = times_ff[scan_addr];
   assign pt_plus   = {1'b0, pt_ff} + (TW+1)'(kpi_pkg::StepMargin);

   // tick arithmetic
   assign tick_sum  = {1'b0, pt_ff} + {1'b0, cmd_time_ff};
   assign tick_wrap = !paused_ff && (count_ff != '0) && (tick_sum >= {1'b0, len_ff})
                      && loop_en_ff && (len_ff != '0);

   // blend arithmetic
   assign diff     = $signed({b_ff[k_ff][VW-1], b_ff[k_ff]}) -
                     $signed({a_ff[k_ff][VW-1], a_ff[k_ff]});
   assign diff_mag = diff[VW] ? (VW+1)'(-diff) : diff;
   assign qmag     = div_rsp.quotient[TW-1:0];
   assign qsigned  = neg_ff ? (~qmag + 1'b1) : qmag;

   // divider shared by wrap and blend
   always_comb begin
      div_req.start    = 1'b0;
      div_req.rem_init = {1'b0, prod_ff[2*TW-1:kpi_pkg::DivSteps]};
      div_req.dividend = prod_ff[kpi_pkg::DivSteps-1:0];
      div_req.divisor  = tn_ff - tp_ff;
      if (state_ff == ST_TICK) begin
         div_req.start    = tick_wrap;
         div_req.rem_init = '0;
         div_req.dividend = tick_sum;
         div_req.divisor  = len_ff;
      end else if (state_ff == ST_DIV_GO) begin
         div_req.start = 1'b1;
      end
   end

   // memory read slot: previous key first, then next key
   assign rd_slot = (state_ff == ST_RD_A) ? op_ff : on_ff;

   // position and joint angle memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADD_SHIFT) begin
         pos_mem[count_ff[KW-1:0]] <= {cmd_val_ff[2], cmd_val_ff[1], cmd_val_ff[0]};
      end
      if (state_ff == ST_CLEAR) begin
         ang_mem[clr_ff] <= '0;
      end else if (req_fire && req_type == kpi_pkg::ReqSetPose && set_pose_ok) begin
         ang_mem[{last_ff, req_joint_index}] <= {req_val_z, req_val_y, req_val_x};
      end
      pos_q_ff <= pos_mem[rd_slot];
      ang_q_ff <= ang_mem[{rd_slot, cmd_joint_ff}];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         len_ff     <= '1;
         loop_en_ff <= 1'b1;
         count_ff   <= '0;
         last_ff    <= '0;
         pt_ff      <= '0;
         paused_ff  <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         // configuration writes
         if (csr_write_enable) begin
            unique case (csr_index)
               kpi_pkg::CsrLoopLength: len_ff     <= csr_write_data;
               kpi_pkg::CsrLoopEnable: loop_en_ff <= csr_write_data[0];
               default: ;
            endcase
         end

         unique case (state_ff)
            // zero the angle memory so joints never posed read as zero
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end

            ST_IDLE: begin
               if (req_valid) begin
                  cmd_type_ff   <= req_type;
                  cmd_time_ff   <= req_time_value;
                  cmd_joint_ff  <= req_joint_index;
                  cmd_val_ff[0] <= req_val_x;
                  cmd_val_ff[1] <= req_val_y;
                  cmd_val_ff[2] <= req_val_z;
                  for (int k = 0; k < 3; k++) begin
                     r_ff[k] <= '0;
                  end
                  err_ff   <= 1'b0;
                  idx_ff   <= '0;
                  cidx_ff  <= '0;
                  found_ff <= 1'b0;
                  p_ff     <= '0;
                  n_ff     <= '0;
                  tp_ff    <= times_ff[0];
                  op_ff    <= ord_ff[0];
                  state_ff <= ST_CUR;
                  unique case (req_type)
                     kpi_pkg::ReqAddKey: begin
                        if (count_ff == CW'(NK)) begin
                           err_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_ADD_SCAN;
                        end
                     end
                     kpi_pkg::ReqTick: state_ff <= ST_TICK;
                     kpi_pkg::ReqQueryPose: begin
                        if (set_pose_ok) begin
                           state_ff <= ST_BR_SCAN;
                        end
                     end
                     kpi_pkg::ReqQueryPos: begin
                        if (count_ff != '0) begin
                           state_ff <= ST_BR_SCAN;
                        end
                     end
                     kpi_pkg::ReqRestart: begin
                        pt_ff     <= '0;
                        paused_ff <= 1'b0;
                     end
                     kpi_pkg::ReqPause:  paused_ff <= 1'b1;
                     kpi_pkg::ReqResume: paused_ff <= 1'b0;
                     kpi_pkg::ReqToggle: paused_ff <= ~paused_ff;
                     kpi_pkg::ReqNextKey: begin
                        if (count_ff != '0) begin
                           state_ff <= ST_NEXT;
                        end
                     end
                     kpi_pkg::ReqPrevKey: begin
                        if (count_ff != '0) begin
                           idx_ff   <= count_ff - 1'b1;
                           state_ff <= ST_PREV;
                        end
                     end
                     default: ;
                  endcase
               end
            end

            // find insert position: first key not earlier than the new time
            ST_ADD_SCAN: begin
               if (idx_ff < count_ff && scan_t < cmd_time_ff) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  state_ff <= ST_ADD_SHIFT;
               end
            end

            // open the gap and drop the new key in; slot number is the fill count
            ST_ADD_SHIFT: begin
               for (int j = 1; j < NK; j++) begin
                  if (CW'(j) > idx_ff && CW'(j) <= count_ff) begin
                     times_ff[j] <= times_ff[j-1];
                     ord_ff[j]   <= ord_ff[j-1];
                  end
               end
               times_ff[idx_ff[KW-1:0]]      <= cmd_time_ff;
               ord_ff[idx_ff[KW-1:0]]        <= count_ff[KW-1:0];
               last_ff                       <= count_ff[KW-1:0];
               count_ff                      <= count_ff + 1'b1;
               state_ff                      <= ST_CUR;
            end

            // advance play time: wrap through the divider (to zero for a zero length), or clamp and pause
            ST_TICK: begin
               state_ff <= ST_CUR;
               if (!paused_ff && count_ff != '0) begin
                  if (tick_sum >= {1'b0, len_ff}) begin
                     if (loop_en_ff) begin
                        if (len_ff == '0) begin
                           pt_ff <= '0;
                        end else begin
                           state_ff <= ST_TICK_DIV;
                        end
                     end else begin
                        pt_ff     <= len_ff;
                        paused_ff <= 1'b1;
                     end
                  end else begin
                     pt_ff <= tick_sum[TW-1:0];
                  end
               end
            end

            ST_TICK_DIV: begin
               if (div_rsp.done) begin
                  pt_ff    <= div_rsp.remainder;
                  state_ff <= ST_CUR;
               end
            end

            // bracket search over sorted keys
            ST_BR_SCAN: begin
               if (idx_ff < count_ff) begin
                  if (scan_t <= pt_ff) begin
                     p_ff  <= idx_ff[KW-1:0];
                     tp_ff <= scan_t;
                     op_ff <= ord_ff[scan_addr];
                  end
                  if (scan_t >= pt_ff) begin
                     n_ff     <= idx_ff[KW-1:0];
                     tn_ff    <= scan_t;
                     on_ff    <= ord_ff[scan_addr];
                     found_ff <= 1'b1;
                     state_ff <= ST_BR_DONE;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  state_ff <= ST_BR_DONE;
               end
            end

            ST_BR_DONE: begin
               mix_ff   <= found_ff && (p_ff != n_ff) && (tp_ff != tn_ff);
               state_ff <= ST_RD_A;
            end

            ST_RD_A: state_ff <= ST_RD_B;

            // previous key values arrive
            ST_RD_B: begin
               for (int k = 0; k < 3; k++) begin
                  if (cmd_type_ff == kpi_pkg::ReqQueryPos) begin
                     a_ff[k] <= pos_q_ff[k*VW +: VW];
                  end else begin
                     a_ff[k] <= ang_q_ff[k*VW +: VW];
                  end
               end
               state_ff <= ST_RD_C;
            end

            // next key values arrive
            ST_RD_C: begin
               for (int k = 0; k < 3; k++) begin
                  if (cmd_type_ff == kpi_pkg::ReqQueryPos) begin
                     b_ff[k] <= pos_q_ff[k*VW +: VW];
                  end else begin
                     b_ff[k] <= ang_q_ff[k*VW +: VW];
                  end
               end
               k_ff <= '0;
               if (mix_ff) begin
                  state_ff <= ST_MUL;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     r_ff[k] <= a_ff[k];
                  end
                  state_ff <= ST_CUR;
               end
            end

            // |b - a| times elapsed time since previous key
            ST_MUL: begin
               neg_ff   <= diff[VW];
               prod_ff  <= diff_mag[VW-1:0] * (pt_ff - tp_ff);
               state_ff <= ST_DIV_GO;
            end

            ST_DIV_GO: state_ff <= ST_DIV_WAIT;

            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  r_ff[k_ff] <= a_ff[k_ff] + $signed(qsigned);
                  if (k_ff == 2'd2) begin
                     state_ff <= ST_CUR;
                  end else begin
                     k_ff     <= k_ff + 1'b1;
                     state_ff <= ST_MUL;
                  end
               end
            end

            // step forward past the margin, else back to the first key
            ST_NEXT: begin
               if ({1'b0, scan_t} > pt_plus) begin
                  pt_ff    <= scan_t;
                  state_ff <= ST_CUR;
               end else if (idx_ff == count_ff - 1'b1) begin
                  pt_ff    <= times_ff[0];
                  state_ff <= ST_CUR;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end

            // step backward past the margin, else to the last key
            ST_PREV: begin
               if (idx_ff == count_ff - 1'b1) begin
                  tlast_ff <= scan_t;
               end
               if (({1'b0, scan_t} + (TW+1)'(kpi_pkg::StepMargin)) < {1'b0, pt_ff}) begin
                  pt_ff    <= scan_t;
                  state_ff <= ST_CUR;
               end else if (idx_ff == '0) begin
                  pt_ff    <= (idx_ff == count_ff - 1'b1) ? scan_t : tlast_ff;
                  state_ff <= ST_CUR;
               end else begin
                  idx_ff <= idx_ff - 1'b1;
               end
            end

            // current key scan, then load the response
            ST_CUR: begin
               if (count_ff == '0 || scan_t >= pt_ff || cidx_ff == count_ff - 1'b1) begin
                  rsp_current_key      <= (count_ff == '0) ? '1 : $signed(cidx_ff);
                  rsp_out_x            <= r_ff[0];
                  rsp_out_y            <= r_ff[1];
                  rsp_out_z            <= r_ff[2];
                  rsp_play_time_now    <= pt_ff;
                  rsp_is_paused        <= paused_ff;
                  rsp_key_count        <= count_ff;
                  rsp_table_full_error <= err_ff;
                  rsp_valid            <= 1'b1;
                  state_ff             <= ST_OUT;
               end else begin
                  cidx_ff <= cidx_ff + 1'b1;
               end
            end

            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // fill count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NK))
      else $error("key count above table size");

   // an accepted request always leaves idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // a taken response is not shown again
   a_single_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("response repeated");

   // full error only reported with a full table
   a_full_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full_error |-> count_ff == CW'(NK))
      else $error("full error with room in table");

   // current key stays inside the table
   a_current_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && count_ff != '0 |-> !rsp_current_key[CW-1] &&
      $unsigned(rsp_current_key) < count_ff)
      else $error("current key out of range");

endmodule

/* src/kpi_div.sv */
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps

module kpi_div (
   input  logic                clock,
   input  logic                reset,
   input  kpi_pkg::div_req_type div_req,
   output kpi_pkg::div_rsp_type div_rsp
);

   logic                         busy_ff;
   logic                         done_ff;
   logic [kpi_pkg::DivCntW-1:0]  cnt_ff;
   logic [kpi_pkg::TimeW-1:0]    rem_ff;
   logic [kpi_pkg::DivSteps-1:0] quo_ff;
   logic [kpi_pkg::TimeW-1:0]    div_ff;

   logic [kpi_pkg::TimeW:0]      shifted;
   logic [kpi_pkg::TimeW+1:0]    trial;
   logic                         borrow;

   // one trial subtraction
   assign shifted = {rem_ff, quo_ff[kpi_pkg::DivSteps-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};
   assign borrow  = trial[kpi_pkg::TimeW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= div_req.rem_init;
            quo_ff  <= div_req.dividend;
            div_ff  <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff <= borrow ? shifted[kpi_pkg::TimeW-1:0] : trial[kpi_pkg::TimeW-1:0];
            quo_ff <= {quo_ff[kpi_pkg::DivSteps-2:0], ~borrow};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == kpi_pkg::DivCntW'(kpi_pkg::DivSteps - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* tb/kpi_checker.sv */
// channel monitor, pose predictor and response comparison for the keyframe interpolator
`timescale 1ns / 1ps

module kpi_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [3:0]         req_type,
   input  logic [15:0]        req_time_value,
   input  logic [4:0]         req_joint_index,
   input  logic signed [15:0] req_val_x,
   input  logic signed [15:0] req_val_y,
   input  logic signed [15:0] req_val_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_out_x,
   input  logic signed [15:0] rsp_out_y,
   input  logic signed [15:0] rsp_out_z,
   input  logic [15:0]        rsp_play_time_now,
   input  logic               rsp_is_paused,
   input  logic [4:0]         rsp_key_count,
   input  logic signed [4:0]  rsp_current_key,
   input  logic               rsp_table_full_error,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_write_data,
   output int                 mismatches,
   output int                 pending
);

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [15:0]        play;
      logic               paused;
      logic [4:0]         count;
      logic [4:0]         cur;
      logic               full_err;
   } pose_status_type;

   pose_status_type pose_queue[$];

   // shadow of the keyframe table and play clock
   logic [15:0]        kf_time[kpi_pkg::MaxKeys];
   logic signed [15:0] kf_pos[kpi_pkg::MaxKeys][3];
   logic signed [15:0] kf_ang[kpi_pkg::MaxKeys][kpi_pkg::JointCount][3];
   bit                 kf_has_ang[kpi_pkg::MaxKeys][kpi_pkg::JointCount];
   int                 n_keys;
   int                 newest_slot;
   int unsigned        play_pos;
   bit                 halted;
   int unsigned        span;
   bit                 wrap_on;

   assign pending = pose_queue.size();

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // bracketing keys around play time; returns 1 when a blend is needed
   function automatic bit find_bracket(output int p, output int n);
      bit hit;
      p = 0;
      n = 0;
      hit = 0;
      for (int i = 0; i < n_keys; i++) begin
         if (kf_time[i] <= play_pos) p = i;
         if (kf_time[i] >= play_pos) begin
            n = i;
            hit = 1;
            break;
         end
      end
      return hit && p != n && kf_time[p] != kf_time[n];
   endfunction

   function automatic logic signed [15:0] lerp(input int a, input int b, input int p,
                                               input int n);
      longint num;
      longint den;
      num = longint'(b - a) * longint'(play_pos - kf_time[p]);
      den = longint'(kf_time[n]) - longint'(kf_time[p]);
      return 16'(a + int'(num / den));
   endfunction

   function automatic logic [4:0] nearest_key();
      if (n_keys == 0) return 5'h1f;
      for (int i = 0; i < n_keys; i++)
         if (kf_time[i] >= play_pos) return 5'(i);
      return 5'(n_keys - 1);
   endfunction

   // advance the shadow state by one request and build its response
   task automatic predict_request(output pose_status_type r);
      int p, n, s, a, b;
      int unsigned t;
      bit mix;
      logic signed [15:0] v[3];
      logic signed [15:0] o[3];
      v[0] = req_val_x;
      v[1] = req_val_y;
      v[2] = req_val_z;
      o[0] = '0; o[1] = '0; o[2] = '0;
      r = '0;
      case (req_type)
         kpi_pkg::ReqAddKey: begin
            if (n_keys >= kpi_pkg::MaxKeys) r.full_err = 1;
            else begin
               s = 0;
               while (s < n_keys && kf_time[s] < req_time_value) s++;
               for (int i = n_keys; i > s; i--) begin
                  kf_time[i] = kf_time[i-1];
                  kf_pos[i] = kf_pos[i-1];
                  kf_ang[i] = kf_ang[i-1];
                  kf_has_ang[i] = kf_has_ang[i-1];
               end
               kf_time[s] = req_time_value;
               kf_pos[s] = v;
               for (int j = 0; j < kpi_pkg::JointCount; j++) kf_has_ang[s][j] = 0;
               newest_slot = s;
               n_keys++;
            end
         end
         kpi_pkg::ReqSetPose: begin
            if (n_keys != 0 && req_joint_index < kpi_pkg::JointCount) begin
               kf_ang[newest_slot][req_joint_index] = v;
               kf_has_ang[newest_slot][req_joint_index] = 1;
            end
         end
         kpi_pkg::ReqTick: begin
            if (!halted && n_keys != 0) begin
               t = play_pos + req_time_value;
               if (t >= span) begin
                  if (wrap_on) t = (span == 0) ? 0 : t % span;
                  else begin
                     t = span;
                     halted = 1;
                  end
               end
               play_pos = t & 16'hffff;
            end
         end
         kpi_pkg::ReqQueryPose: begin
            if (n_keys != 0 && req_joint_index < kpi_pkg::JointCount) begin
               mix = find_bracket(p, n);
               for (int k = 0; k < 3; k++) begin
                  a = kf_has_ang[p][req_joint_index] ? kf_ang[p][req_joint_index][k] : 0;
                  b = kf_has_ang[n][req_joint_index] ? kf_ang[n][req_joint_index][k] : 0;
                  o[k] = mix ? lerp(a, b, p, n) : 16'(a);
               end
            end
         end
         kpi_pkg::ReqQueryPos: begin
            if (n_keys != 0) begin
               mix = find_bracket(p, n);
               for (int k = 0; k < 3; k++)
                  o[k] = mix ? lerp(kf_pos[p][k], kf_pos[n][k], p, n) : kf_pos[p][k];
            end
         end
         kpi_pkg::ReqRestart: begin
            play_pos = 0;
            halted = 0;
         end
         kpi_pkg::ReqPause:  halted = 1;
         kpi_pkg::ReqResume: halted = 0;
         kpi_pkg::ReqToggle: halted = !halted;
         kpi_pkg::ReqNextKey: begin
            if (n_keys != 0) begin
               t = kf_time[0];
               for (int i = 0; i < n_keys; i++)
                  if (kf_time[i] > play_pos + kpi_pkg::StepMargin) begin
                     t = kf_time[i];
                     break;
                  end
               play_pos = t;
            end
         end
         kpi_pkg::ReqPrevKey: begin
            if (n_keys != 0) begin
               t = kf_time[n_keys-1];
               for (int i = n_keys - 1; i >= 0; i--)
                  if (kf_time[i] + kpi_pkg::StepMargin < play_pos) begin
                     t = kf_time[i];
                     break;
                  end
               play_pos = t;
            end
         end
         default: ;
      endcase
      r.x = o[0];
      r.y = o[1];
      r.z = o[2];
      r.play = play_pos[15:0];
      r.paused = halted;
      r.count = 5'(n_keys);
      r.cur = nearest_key();
   endtask

   // watch config, requests and responses
   always @(posedge clock) begin
      pose_status_type e;
      if (reset) begin
         n_keys = 0;
         newest_slot = 0;
         play_pos = 0;
         halted = 0;
         span = 65535;
         wrap_on = 1;
         for (int i = 0; i < kpi_pkg::MaxKeys; i++)
            for (int j = 0; j < kpi_pkg::JointCount; j++) kf_has_ang[i][j] = 0;
         pose_queue.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pose_queue.size() == 0) report("unexpected response", 0, 0);
            else begin
               e = pose_queue.pop_front();
               if (rsp_out_x !== e.x) report("out_x", rsp_out_x, e.x);
               if (rsp_out_y !== e.y) report("out_y", rsp_out_y, e.y);
               if (rsp_out_z !== e.z) report("out_z", rsp_out_z, e.z);
               if (rsp_play_time_now !== e.play)
                  report("play_time_now", rsp_play_time_now, e.play);
               if (rsp_is_paused !== e.paused) report("is_paused", rsp_is_paused, e.paused);
               if (rsp_key_count !== e.count) report("key_count", rsp_key_count, e.count);
               if (rsp_current_key !== e.cur)
                  report("current_key", rsp_current_key, $signed(e.cur));
               if (rsp_table_full_error !== e.full_err)
                  report("table_full_error", rsp_table_full_error, e.full_err);
            end
         end
         if (csr_write_enable) begin
            if (csr_index == kpi_pkg::CsrLoopLength) span = csr_write_data;
            else wrap_on = csr_write_data[0];
         end
         if (req_valid && !req_stall) begin
            predict_request(e);
            pose_queue.push_back(e);
         end
      end
   end

endmodule

/* tb/testbench.sv */
// stimulus, clocking and verdict for the keyframe interpolator testbench
`timescale 1ns / 1ps

module testbench;

   localparam int CycleLimit = 2_000_000;
   localparam int DrainCycles = 200;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [3:0]         req_type = '0;
   logic [15:0]        req_time_value = '0;
   logic [4:0]         req_joint_index = '0;
   logic signed [15:0] req_val_x = '0;
   logic signed [15:0] req_val_y = '0;
   logic signed [15:0] req_val_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [15:0]        rsp_play_time_now;
   logic               rsp_is_paused;
   logic [4:0]         rsp_key_count;
   logic signed [4:0]  rsp_current_key;
   logic               rsp_table_full_error;
   logic               csr_write_enable = 0;
   logic               csr_index = 0;
   logic [15:0]        csr_write_data = '0;

   int  mismatches;
   int  pending;
   int  cycles = 0;
   bit  no_gaps = 0;
   bit  hold_off = 0;
   int  span_now = 65535;

   keyframe_pose_interpolator dut (.*);

   kpi_checker u_checker (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // response side stall: random gaps, plus a long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         n = $urandom_range(0, 99);
         if (no_gaps || n < 55) rsp_stall <= 0;
         else rsp_stall <= 1;
         n = (n > 95) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         repeat (n) @(posedge clock);
      end
   end

   task automatic send_request(input logic [3:0] kind, input logic [15:0] tv,
                               input logic [4:0] joint, input logic [15:0] x,
                               input logic [15:0] y, input logic [15:0] z);
      int gap;
      req_type <= kind;
      req_time_value <= tv;
      req_joint_index <= joint;
      req_val_x <= x;
      req_val_y <= y;
      req_val_z <= z;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = $urandom_range(0, 99);
      if (no_gaps || gap < 55) gap = 0;
      else if (gap < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait out every outstanding response so the block is idle
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_loop(input int length, input bit wrap);
      csr_write_enable <= 1;
      csr_index <= kpi_pkg::CsrLoopLength;
      csr_write_data <= 16'(length);
      @(posedge clock);
      csr_index <= kpi_pkg::CsrLoopEnable;
      csr_write_data <= {15'($urandom), wrap};
      @(posedge clock);
      csr_write_enable <= 0;
      span_now = length;
   endtask

   // one random request, mostly meaningful commands
   task automatic random_request();
      int pick;
      logic [3:0] kind;
      logic [15:0] tv;
      logic [4:0] joint;
      pick = $urandom_range(0, 99);
      if (pick < 4) kind = kpi_pkg::ReqAddKey;
      else if (pick < 16) kind = kpi_pkg::ReqSetPose;
      else if (pick < 38) kind = kpi_pkg::ReqTick;
      else if (pick < 56) kind = kpi_pkg::ReqQueryPose;
      else if (pick < 72) kind = kpi_pkg::ReqQueryPos;
      else if (pick < 96)
         kind = 4'($urandom_range(kpi_pkg::ReqRestart, kpi_pkg::ReqPrevKey));
      else kind = 4'($urandom_range(11, 15));
      pick = $urandom_range(0, 9);
      if (kind == kpi_pkg::ReqTick)
         tv = (pick < 8) ? 16'($urandom_range(0, 64)) : 16'($urandom);
      else
         tv = (pick < 7) ? 16'($urandom_range(0, span_now > 700 ? 700 : span_now + 4))
                         : 16'($urandom);
      joint = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, kpi_pkg::JointCount - 1))
                                         : 5'($urandom);
      send_request(kind, tv, joint, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      int spans[8] = '{65535, 600, 1, 0, 300, 65535, 40, 1000};
      bit wraps[8] = '{1, 0, 1, 0, 1, 0, 0, 1};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table first, then extremes and equal key times
      send_request(kpi_pkg::ReqQueryPos, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqQueryPose, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqTick, 16'hffff, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqNextKey, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqPrevKey, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqSetPose, 0, 0, 16'h7fff, 16'h7fff, 16'h7fff);
      send_request(4'd15, 16'hffff, 5'h1f, 16'hffff, 16'hffff, 16'hffff);
      send_request(kpi_pkg::ReqAddKey, 100, 0, 16'h7fff, 16'h8000, 16'h0000);
      send_request(kpi_pkg::ReqSetPose, 0, 0, 16'h8000, 16'h7fff, 16'hffff);
      send_request(kpi_pkg::ReqSetPose, 0, 18, 16'h7fff, 16'h8000, 16'h0001);
      send_request(kpi_pkg::ReqSetPose, 0, 19, 16'h1234, 16'h1234, 16'h1234);
      send_request(kpi_pkg::ReqAddKey, 0, 5'h1f, 16'h8000, 16'h7fff, 16'hffff);
      send_request(kpi_pkg::ReqAddKey, 100, 0, 16'h0100, 16'hff00, 16'h0000);
      send_request(kpi_pkg::ReqAddKey, 16'hffff, 0, 16'h0000, 16'h7fff, 16'h8000);
      send_request(kpi_pkg::ReqTick, 50, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqQueryPos, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqQueryPose, 0, 18, 0, 0, 0);
      send_request(kpi_pkg::ReqQueryPose, 0, 31, 0, 0, 0);
      send_request(kpi_pkg::ReqPause, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqTick, 10, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqToggle, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqNextKey, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqPrevKey, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqResume, 0, 0, 0, 0, 0);
      send_request(kpi_pkg::ReqRestart, 0, 0, 0, 0, 0);
      drain();

      // random phases over several loop settings
      for (int ph = 0; ph < 8; ph++) begin
         write_loop(spans[ph], wraps[ph]);
         no_gaps = (ph == 2 || ph == 5);
         for (int i = 0; i < 200; i++) begin
            if (ph == 1 && i == 50) hold_off = 1;
            if (ph == 3 && i == 100) begin
               req_valid <= 0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
            random_request();
         end
         drain();
      end

      if (mismatches == 0 && pending == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
